// ----- sv/ato_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt orientation package
// Widths, angle constants and the arctangent table shared by the tilt
// orientation datapath.
// ----------------------------------------------------------------------------
package ato_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int TAB_BITS        = 24;
	localparam int ROUND_SH        = TAB_BITS - ANGLE_FRAC_BITS;

	// Squares and sums of the raw axes.
	localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W = 2 * SAMPLE_BITS;
	localparam int MAG_W = SUM_W / 2;

	// Horizontal norm is taken as the root of (x^2+y^2) scaled into [2^60, 2^62).
	localparam int U_W           = SUM_W + 2;
	localparam int RAD_PAD       = 28;
	localparam int RAD_W         = U_W + RAD_PAD;
	localparam int RS_W          = RAD_W / 2;
	localparam int ZS_W          = SAMPLE_BITS + RAD_PAD / 2 + SUM_W / 2;
	localparam int S_NORM_STEPS  = 5;

	// CORDIC datapath.
	localparam int CORDIC_STEPS     = 24;
	localparam int CORDIC_NORM_STEPS = 6;
	localparam int NORM_BIT         = 40;
	localparam int VEC_W            = 50;
	localparam int ACC_W            = 36;
	localparam int CORDIC_LAT       = 2 + CORDIC_NORM_STEPS + CORDIC_STEPS;

	localparam int INCL_W   = 14;
	localparam int ORIENT_W = 15;
	localparam int THR_W    = 14;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5 << ANGLE_FRAC_BITS);

	localparam logic signed [ACC_W-1:0] DEG90  = ACC_W'(90) <<< TAB_BITS;
	localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180) <<< TAB_BITS;
	localparam logic signed [ACC_W-1:0] DEG360 = ACC_W'(360) <<< TAB_BITS;

	typedef struct packed {
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [ACC_W-1:0] acc;
	} ato_vec_t;

	// atan(2^-i) in degrees, scaled by 2^24 and rounded.
	function automatic logic signed [ACC_W-1:0] atan_deg(input int idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			0:       v = ACC_W'(754974720);
			1:       v = ACC_W'(445687602);
			2:       v = ACC_W'(235489088);
			3:       v = ACC_W'(119537938);
			4:       v = ACC_W'(60000934);
			5:       v = ACC_W'(30029717);
			6:       v = ACC_W'(15018523);
			7:       v = ACC_W'(7509720);
			8:       v = ACC_W'(3754917);
			9:       v = ACC_W'(1877466);
			10:      v = ACC_W'(938734);
			11:      v = ACC_W'(469367);
			12:      v = ACC_W'(234684);
			13:      v = ACC_W'(117342);
			14:      v = ACC_W'(58671);
			15:      v = ACC_W'(29335);
			16:      v = ACC_W'(14668);
			17:      v = ACC_W'(7334);
			18:      v = ACC_W'(3667);
			19:      v = ACC_W'(1833);
			20:      v = ACC_W'(917);
			21:      v = ACC_W'(458);
			22:      v = ACC_W'(229);
			23:      v = ACC_W'(115);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Clamp an angle to [0, limit] and round half up to output units.
	function automatic logic [ACC_W-ROUND_SH-1:0] to_units(
		input logic signed [ACC_W-1:0] acc,
		input logic signed [ACC_W-1:0] limit
	);
		logic signed [ACC_W-1:0] c;
		logic [ACC_W-1:0] r;
		c = acc;
		if (acc < 0)
			c = '0;
		else if (acc > limit)
			c = limit;
		r = ACC_W'(c) + (ACC_W'(1) << (ROUND_SH - 1));
		return r[ACC_W-1:ROUND_SH];
	endfunction

endpackage

// ----- sv/ato_delay.sv -----
// ----------------------------------------------------------------------------
// Tilt orientation delay line
// A shift line of registers that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module ato_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++)
				line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < D; i++)
				line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[D-1];

endmodule

// ----- sv/ato_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Tilt orientation square root cell
// One restoring digit step of an integer square root: takes two radicand
// bits and decides one root bit.
// ----------------------------------------------------------------------------
module ato_sqrt_cell #(
	parameter int QW = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*QW-1:0] rad,
	input  logic [QW+1:0]   rem,
	input  logic [QW-1:0]   root,
	output logic [2*QW-1:0] rad_nx,
	output logic [QW+1:0]   rem_nx,
	output logic [QW-1:0]   root_nx
);

	logic [2*QW-1:0] rad_q;
	logic [QW+1:0]   rem_q;
	logic [QW-1:0]   root_q;
	logic [QW+1:0]   cur;
	logic [QW+1:0]   trial;

	assign cur   = {rem[QW-1:0], rad[2*QW-1 -: 2]};
	assign trial = {root, 2'b01};

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= {rad[2*QW-3:0], 2'b00};
			if (cur >= trial) begin
				rem_q  <= cur - trial;
				root_q <= {root[QW-2:0], 1'b1};
			end else begin
				rem_q  <= cur;
				root_q <= {root[QW-2:0], 1'b0};
			end
		end
	end

	assign rad_nx  = rad_q;
	assign rem_nx  = rem_q;
	assign root_nx = root_q;

endmodule

// ----- sv/ato_isqrt.sv -----
// ----------------------------------------------------------------------------
// Tilt orientation integer square root
// A chain of square root cells, one root bit per cell,
// giving the truncated root.
// ----------------------------------------------------------------------------
module ato_isqrt #(
	parameter int OW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [OW-1:0]   radicand,
	output logic [OW/2-1:0] root
);

	localparam int QW = OW / 2;

	logic [OW-1:0] rad_w  [QW+1];
	logic [QW+1:0] rem_w  [QW+1];
	logic [QW-1:0] root_w [QW+1];

	assign rad_w[0]  = radicand;
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		ato_sqrt_cell #(.QW(QW)) u_cell (
			.clk     (clk),
			.en      (en),
			.rad     (rad_w[i]),
			.rem     (rem_w[i]),
			.root    (root_w[i]),
			.rad_nx  (rad_w[i+1]),
			.rem_nx  (rem_w[i+1]),
			.root_nx (root_w[i+1])
		);
	end

	assign root = root_w[QW];

endmodule

// ----- sv/ato_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// Tilt orientation CORDIC cell
// One vectoring micro-rotation that drives the second coordinate towards
// zero and accumulates the angle turned.
// ----------------------------------------------------------------------------
module ato_cordic_cell
	import ato_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic     clk,
	input  logic     en,
	input  ato_vec_t vec,
	output ato_vec_t vec_nx
);

	ato_vec_t vec_q;
	logic signed [VEC_W-1:0] da;
	logic signed [VEC_W-1:0] db;

	assign da = $signed(vec.b) >>> IDX;
	assign db = $signed(vec.a) >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!vec.b[VEC_W-1]) begin
				vec_q.a   <= vec.a + da;
				vec_q.b   <= vec.b - db;
				vec_q.acc <= vec.acc + atan_deg(IDX);
			end else begin
				vec_q.a   <= vec.a - da;
				vec_q.b   <= vec.b + db;
				vec_q.acc <= vec.acc - atan_deg(IDX);
			end
		end
	end

	assign vec_nx = vec_q;

endmodule

// ----- sv/ato_cordic.sv -----
// ----------------------------------------------------------------------------
// Tilt orientation angle unit
// Pipelined atan2(b, a) in degrees: operand normalisation, quadrant fold and
// a chain of CORDIC cells.
// ----------------------------------------------------------------------------
module ato_cordic
	import ato_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic signed [VEC_W-1:0] a,
	input  logic signed [VEC_W-1:0] b,
	output logic signed [ACC_W-1:0] angle
);

	logic signed [VEC_W-1:0] na_q [CORDIC_NORM_STEPS+1];
	logic signed [VEC_W-1:0] nb_q [CORDIC_NORM_STEPS+1];
	logic [VEC_W-1:0]        nm_q [CORDIC_NORM_STEPS+1];
	logic                    nz_q [CORDIC_NORM_STEPS+1];
	logic [VEC_W-1:0]        abs_a;
	logic [VEC_W-1:0]        abs_b;
	ato_vec_t                pre_q;
	ato_vec_t                vec_w [CORDIC_STEPS+1];
	logic [0:0]              zero_d;

	assign abs_a = a[VEC_W-1] ? VEC_W'(-a) : VEC_W'(a);
	assign abs_b = b[VEC_W-1] ? VEC_W'(-b) : VEC_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			na_q[0] <= a;
			nb_q[0] <= b;
			nm_q[0] <= (abs_a > abs_b) ? abs_a : abs_b;
			nz_q[0] <= (a == '0) && (b == '0);
		end
	end

	// Binary search for the doubling count that puts the larger magnitude
	// at bit NORM_BIT when it lies below that bit.
	for (genvar j = 0; j < CORDIC_NORM_STEPS; j++) begin : g_norm
		localparam int K = 32 >> j;
		always_ff @(posedge clk) begin
			if (en) begin
				if (nm_q[j] < (VEC_W'(1) << (NORM_BIT + 1 - K))) begin
					nm_q[j+1] <= nm_q[j] << K;
					na_q[j+1] <= na_q[j] <<< K;
					nb_q[j+1] <= nb_q[j] <<< K;
				end else begin
					nm_q[j+1] <= nm_q[j];
					na_q[j+1] <= na_q[j];
					nb_q[j+1] <= nb_q[j];
				end
				nz_q[j+1] <= nz_q[j];
			end
		end
	end

	// Fold the left half plane onto the right by a quarter turn.
	always_ff @(posedge clk) begin
		if (en) begin
			if (na_q[CORDIC_NORM_STEPS][VEC_W-1]) begin
				if (!nb_q[CORDIC_NORM_STEPS][VEC_W-1]) begin
					pre_q.a   <= nb_q[CORDIC_NORM_STEPS];
					pre_q.b   <= -na_q[CORDIC_NORM_STEPS];
					pre_q.acc <= DEG90;
				end else begin
					pre_q.a   <= -nb_q[CORDIC_NORM_STEPS];
					pre_q.b   <= na_q[CORDIC_NORM_STEPS];
					pre_q.acc <= -DEG90;
				end
			end else begin
				pre_q.a   <= na_q[CORDIC_NORM_STEPS];
				pre_q.b   <= nb_q[CORDIC_NORM_STEPS];
				pre_q.acc <= '0;
			end
		end
	end

	assign vec_w[0] = pre_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		ato_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.vec    (vec_w[i]),
			.vec_nx (vec_w[i+1])
		);
	end

	ato_delay #(.W(1), .D(CORDIC_STEPS + 1)) u_zero_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (nz_q[CORDIC_NORM_STEPS]),
		.q      (zero_d)
	);

	// atan2 of the zero vector is taken as zero.
	assign angle = zero_d[0] ? '0 : vec_w[CORDIC_STEPS].acc;

endmodule

// ----- sv/accel_tilt_orientation_top.sv -----
// ----------------------------------------------------------------------------
// Accelerometer tilt orientation
// Vector magnitude, inclination from vertical and horizontal heading of one
// signed three-axis sample.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the output is not stalled and
// returns one result per sample, in order. The longest path runs through the
// 31-cell square root chain for the horizontal norm followed by the 32-stage
// CORDIC angle unit; the magnitude root and the heading CORDIC run alongside
// them. The whole pipeline advances together and holds when a result is
// waiting on the output and the sink is not ready, so the input is not ready
// in exactly those cycles. Angles are in 1/64 degree; the heading reads zero
// while the inclination lies below flat_threshold (reset 5 degrees).
module accel_tilt_orientation_top
	import ato_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // accel_x, accel_y, accel_z
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [47:0]       m_axis_tdata,  // magnitude, inclination, orientation, pad
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata
);

	localparam int XY_DLY    = 1 + S_NORM_STEPS + RS_W;
	localparam int MAG_DLY   = S_NORM_STEPS + RS_W - MAG_W + CORDIC_LAT;
	localparam int VALID_DLY = 2 + S_NORM_STEPS + RS_W + CORDIC_LAT;
	localparam logic [INCL_W-1:0] INCL_LEVEL = INCL_W'(90 << ANGLE_FRAC_BITS);
	localparam logic [INCL_W-1:0] INCL_MAX   = INCL_W'(180 << ANGLE_FRAC_BITS);
	localparam logic [ORIENT_W-1:0] ORIENT_MAX = ORIENT_W'(360 << ANGLE_FRAC_BITS);

	logic en;
	logic [THR_W-1:0] thr_q;

	logic signed [SAMPLE_BITS-1:0] x_in, y_in, z_in;
	logic signed [SUM_W-1:0]       px, py, pz;
	logic signed [SAMPLE_BITS-1:0] x_s1, y_s1, z_s1;
	logic [SQ_W-1:0]               xx_s1, yy_s1, zz_s1;
	logic [SUM_W-1:0]              t_s2;

	logic [U_W-1:0]          u_q  [S_NORM_STEPS+1];
	logic signed [ZS_W-1:0]  zs_q [S_NORM_STEPS+1];

	logic [RS_W-1:0]   rs;
	logic [MAG_W-1:0]  mag_root;
	logic [ZS_W-1:0]   zs_d;
	logic [MAG_W-1:0]  mag_d;
	logic [SAMPLE_BITS-1:0] x_d, y_d;
	logic [0:0]        valid_in, valid_d;

	logic signed [ACC_W-1:0] angle_i, angle_o;
	logic [ACC_W-ROUND_SH-1:0] incl_u, orient_u;
	logic [INCL_W-1:0]   incl;
	logic [ORIENT_W-1:0] orient;

	logic              out_valid_q;
	logic [47:0]       out_data_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign x_in = $signed(s_axis_tdata[15:0]);
	assign y_in = $signed(s_axis_tdata[31:16]);
	assign z_in = $signed(s_axis_tdata[47:32]);
	assign px   = x_in * x_in;
	assign py   = y_in * y_in;
	assign pz   = z_in * z_in;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x_in;
			y_s1  <= y_in;
			z_s1  <= z_in;
			xx_s1 <= SQ_W'(px);
			yy_s1 <= SQ_W'(py);
			zz_s1 <= SQ_W'(pz);
		end
	end

	// A zero horizontal norm leaves z unscaled.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= SUM_W'(xx_s1) + SUM_W'(yy_s1) + SUM_W'(zz_s1);
			u_q[0]  <= U_W'(xx_s1) + U_W'(yy_s1);
			if (x_s1 == '0 && y_s1 == '0)
				zs_q[0] <= ZS_W'(z_s1);
			else
				zs_q[0] <= ZS_W'(z_s1) <<< (RAD_PAD / 2);
		end
	end

	// Largest even shift keeping x^2+y^2 below 2^34; z follows at half rate.
	for (genvar j = 0; j < S_NORM_STEPS; j++) begin : g_snorm
		localparam int K = (j < S_NORM_STEPS - 1) ? (16 >> j) : 2;
		always_ff @(posedge clk) begin
			if (en) begin
				if (u_q[j] != '0 && u_q[j] < (U_W'(1) << (U_W - K))) begin
					u_q[j+1]  <= u_q[j] << K;
					zs_q[j+1] <= zs_q[j] <<< (K / 2);
				end else begin
					u_q[j+1]  <= u_q[j];
					zs_q[j+1] <= zs_q[j];
				end
			end
		end
	end

	ato_isqrt #(.OW(RAD_W)) u_rs_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({u_q[S_NORM_STEPS], {RAD_PAD{1'b0}}}),
		.root     (rs)
	);

	ato_isqrt #(.OW(SUM_W)) u_mag_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (t_s2),
		.root     (mag_root)
	);

	ato_delay #(.W(ZS_W), .D(RS_W)) u_zs_dly (
		.clk (clk), .arst_n (arst_n), .en (en),
		.d   (zs_q[S_NORM_STEPS]), .q (zs_d)
	);

	ato_delay #(.W(MAG_W), .D(MAG_DLY)) u_mag_dly (
		.clk (clk), .arst_n (arst_n), .en (en),
		.d   (mag_root), .q (mag_d)
	);

	ato_delay #(.W(SAMPLE_BITS), .D(XY_DLY)) u_x_dly (
		.clk (clk), .arst_n (arst_n), .en (en),
		.d   (x_s1), .q (x_d)
	);

	ato_delay #(.W(SAMPLE_BITS), .D(XY_DLY)) u_y_dly (
		.clk (clk), .arst_n (arst_n), .en (en),
		.d   (y_s1), .q (y_d)
	);

	assign valid_in = s_axis_tvalid;

	ato_delay #(.W(1), .D(VALID_DLY)) u_valid_dly (
		.clk (clk), .arst_n (arst_n), .en (en),
		.d   (valid_in), .q (valid_d)
	);

	ato_cordic u_incl_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.a      (VEC_W'(rs)),
		.b      (VEC_W'($signed(zs_d))),
		.angle  (angle_i)
	);

	ato_cordic u_orient_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.a      (VEC_W'($signed(y_d))),
		.b      (VEC_W'($signed(x_d))),
		.angle  (angle_o)
	);

	assign incl_u   = to_units(DEG90 - angle_i, DEG180);
	assign orient_u = to_units(angle_o + DEG180, DEG360);
	assign incl     = incl_u[INCL_W-1:0];
	assign orient   = (incl_u < (ACC_W-ROUND_SH)'(thr_q)) ? '0 : orient_u[ORIENT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_d[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {3'b000, orient, incl, mag_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[29:16] <= INCL_MAX && m_axis_tdata[44:30] <= ORIENT_MAX))
		else $error("angle out of range");

	a_zero_sample_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[15:0] == '0) |-> (m_axis_tdata[29:16] == INCL_LEVEL))
		else $error("zero sample does not read as level");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("pending result changed");

endmodule
